[rtl/bsa_pkg.sv]
`default_nettype none

package bsa_pkg;

	// Default geometry of the slot bitmap
	localparam int CAPACITY  = 1024;
	localparam int WORD_BITS = 64;

	// Field widths fixed by the item and register formats
	localparam int ACT_W        = 11;
	localparam int SLOT_FIELD_W = 10;
	localparam int STATUS_W     = 2;

	localparam logic [ACT_W-1:0] ACT_RESET = 11'd1024;

	// Request kinds
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_ID = 2'd2;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_PEND
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic clear;     // write zero to the current word, advance
		logic start;     // item accepted this cycle
		logic scan;      // read next word, advance the scan
		logic out_load;  // move pending result into the output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_last;  // clearing pass is on the last word
		logic bad_free;    // incoming free names a slot out of range
		logic done;        // scan has its answer this cycle
	} sts_t;

endpackage

`default_nettype wire

[rtl/bsa_if.sv]
`default_nettype none

// Request channel
interface bsa_req_if;
	logic                              valid;
	logic                              ready;
	logic                              mode;
	logic [bsa_pkg::SLOT_FIELD_W-1:0]  release_slot;

	modport source (output valid, mode, release_slot, input ready);
	modport sink   (input valid, mode, release_slot, output ready);
endinterface

// Result channel
interface bsa_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [bsa_pkg::SLOT_FIELD_W-1:0]  granted_slot;
	logic [bsa_pkg::STATUS_W-1:0]      status;

	modport source (output valid, granted_slot, status, input ready);
	modport sink   (input valid, granted_slot, status, output ready);
endinterface

// Register write channel
interface bsa_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [bsa_pkg::ACT_W-1:0]   active_slots;

	modport source (output valid, active_slots, input ready);
	modport sink   (input valid, active_slots, output ready);
endinterface

`default_nettype wire

[rtl/bitmap_slot_allocator_top.sv]
`default_nettype none

// Sequence: a free of an out-of-range slot skips the scan and goes to the result wait;
// an allocate or free reads the bitmap from word 0 until the word that settles it, one
// word read per cycle from the store, then waits until the output register can take it.
// Throughput: one item at a time; the next item is taken once the result is in the output register.
// Reset: after arst_n the bitmap is cleared one word a cycle, all NUM_WORDS words (16),
// with req.ready low; register writes are taken throughout.
module bitmap_slot_allocator_top #(
	parameter int CAPACITY  = bsa_pkg::CAPACITY,
	parameter int WORD_BITS = bsa_pkg::WORD_BITS
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bsa_req_if.sink    req,
	bsa_rsp_if.source  rsp,
	bsa_cfg_if.sink    cfg
);

	bsa_pkg::cmd_t cmd;
	bsa_pkg::sts_t sts;

	// Register channel never stalls
	assign cfg.ready = 1'b1;

	// Sequencer
	bsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Bitmap store and scan datapath
	bsa_dp #(
		.CAPACITY  (CAPACITY),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.in_mode          (req.mode),
		.in_release_slot  (req.release_slot),
		.cfg_valid        (cfg.valid),
		.cfg_active_slots (cfg.active_slots),
		.granted_slot     (rsp.granted_slot),
		.status           (rsp.status)
	);

endmodule

`default_nettype wire

[rtl/bsa_ctrl.sv]
`default_nettype none

module bsa_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	output bsa_pkg::cmd_t       cmd,
	input  wire bsa_pkg::sts_t  sts
);

	bsa_pkg::state_t state_q;
	bsa_pkg::state_t state_d;
	logic            out_valid_q;

	// State register and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bsa_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_ready     = 1'b0;
		case (state_q)
			bsa_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = bsa_pkg::ST_IDLE;
				end
			end
			bsa_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
				if (in_valid) begin
					state_d = sts.bad_free ? bsa_pkg::ST_PEND : bsa_pkg::ST_SCAN;
				end
			end
			bsa_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.done) begin
					state_d = bsa_pkg::ST_PEND;
				end
			end
			bsa_pkg::ST_PEND: begin
				// wait until the output register is free or draining
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = bsa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bsa_pkg::ST_CLEAR;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[rtl/bsa_dp.sv]
`default_nettype none

module bsa_dp #(
	parameter int CAPACITY  = bsa_pkg::CAPACITY,
	parameter int WORD_BITS = bsa_pkg::WORD_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire bsa_pkg::cmd_t                     cmd,
	output bsa_pkg::sts_t                          sts,
	input  wire logic                              in_mode,
	input  wire logic [bsa_pkg::SLOT_FIELD_W-1:0]  in_release_slot,
	input  wire logic                              cfg_valid,
	input  wire logic [bsa_pkg::ACT_W-1:0]         cfg_active_slots,
	output logic [bsa_pkg::SLOT_FIELD_W-1:0]       granted_slot,
	output logic [bsa_pkg::STATUS_W-1:0]           status
);

	localparam int NUM_WORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
	localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int LIM_W     = $clog2(CAPACITY + 1);
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int ACT_CMP_W = (bsa_pkg::ACT_W > LIM_W) ? bsa_pkg::ACT_W : LIM_W;
	localparam int REL_CMP_W = (bsa_pkg::SLOT_FIELD_W > LIM_W) ? bsa_pkg::SLOT_FIELD_W : LIM_W;

	localparam logic [WIDX_W-1:0]    LAST_WORD = WIDX_W'(NUM_WORDS - 1);
	localparam logic [LIM_W-1:0]     WB_L      = LIM_W'(WORD_BITS);
	localparam logic [LIM_W-1:0]     CAP_L     = LIM_W'(CAPACITY);
	localparam logic [WORD_BITS-1:0] ONE_W     = WORD_BITS'(1);

	// Bitmap store, one bit per slot, set when in use
	logic [WORD_BITS-1:0] mem [NUM_WORDS];

	logic [bsa_pkg::ACT_W-1:0]        active_q;
	logic                             mode_q;
	logic [LIM_W-1:0]                 lim_q;
	logic [WIDX_W-1:0]                widx_q;
	logic [LIM_W-1:0]                 rem_q;
	logic [LIM_W-1:0]                 off_q;
	logic                             vld_s1;
	logic [WIDX_W-1:0]                idx_s1;
	logic [LIM_W-1:0]                 rem_s1;
	logic [LIM_W-1:0]                 off_s1;
	logic [WORD_BITS-1:0]             rd_s1;
	logic [bsa_pkg::SLOT_FIELD_W-1:0] res_granted_q;
	logic [bsa_pkg::STATUS_W-1:0]     res_status_q;
	logic [bsa_pkg::SLOT_FIELD_W-1:0] out_granted_q;
	logic [bsa_pkg::STATUS_W-1:0]     out_status_q;

	logic [LIM_W-1:0]     lim_now;
	logic                 alloc_s1;
	logic [WORD_BITS-1:0] range_mask;
	logic [WORD_BITS-1:0] free_bits;
	logic                 found;
	logic [BIT_W-1:0]     first_bit;
	logic                 last_word;
	logic                 in_word;
	logic [BIT_W-1:0]     free_bit;
	logic [LIM_W-1:0]     grant;
	logic                 we_scan;
	logic                 we;
	logic [WIDX_W-1:0]    waddr;
	logic [WORD_BITS-1:0] wdata;

	// Active count saturated at the capacity
	always_comb begin
		if (ACT_CMP_W'(active_q) > ACT_CMP_W'(CAPACITY)) begin
			lim_now = CAP_L;
		end else begin
			lim_now = LIM_W'(active_q);
		end
	end

	assign sts.bad_free = (in_mode == bsa_pkg::MODE_FREE) &&
		(REL_CMP_W'(in_release_slot) >= REL_CMP_W'(lim_now));
	assign sts.clear_last = (widx_q == LAST_WORD);

	// Word check: lowest clear bit below the active count, or the free target
	always_comb begin
		alloc_s1 = (mode_q == bsa_pkg::MODE_ALLOC);
		for (int b = 0; b < WORD_BITS; b++) begin
			range_mask[b] = (LIM_W'(b) < rem_s1);
		end
		free_bits = ~rd_s1 & range_mask;
		found     = |free_bits;
		first_bit = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (free_bits[b]) begin
				first_bit = BIT_W'(b);
			end
		end
		last_word = (rem_s1 <= WB_L);
		in_word   = (off_s1 < WB_L);
		free_bit  = off_s1[BIT_W-1:0];
		// word base is the limit less the slots left from this word on
		grant     = lim_q - rem_s1 + LIM_W'(first_bit);
		we_scan   = vld_s1 && (alloc_s1 ? found : in_word);
	end

	assign sts.done = vld_s1 && (alloc_s1 ? (found || last_word) : in_word);

	// Write port: clearing pass or scan update
	always_comb begin
		we    = cmd.clear || we_scan;
		waddr = cmd.clear ? widx_q : idx_s1;
		if (cmd.clear) begin
			wdata = '0;
		end else if (alloc_s1) begin
			wdata = rd_s1 | (ONE_W << first_bit);
		end else begin
			wdata = rd_s1 & ~(ONE_W << free_bit);
		end
	end

	// Bitmap store, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_s1 <= mem[widx_q];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= bsa_pkg::ACT_RESET;
			widx_q   <= '0;
			vld_s1   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				active_q <= cfg_active_slots;
			end
			if (cmd.start) begin
				widx_q <= '0;
			end else if (cmd.clear) begin
				widx_q <= (widx_q == LAST_WORD) ? '0 : widx_q + 1'b1;
			end else if (cmd.scan && (widx_q != LAST_WORD)) begin
				widx_q <= widx_q + 1'b1;
			end
			vld_s1 <= cmd.scan && !sts.done;
		end
	end

	// Scan counters and result payload
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mode_q <= in_mode;
			lim_q  <= lim_now;
			rem_q  <= lim_now;
			off_q  <= LIM_W'(in_release_slot);
		end else if (cmd.scan) begin
			rem_q <= (rem_q > WB_L) ? rem_q - WB_L : '0;
			off_q <= (off_q >= WB_L) ? off_q - WB_L : '0;
		end
		idx_s1 <= widx_q;
		rem_s1 <= rem_q;
		off_s1 <= off_q;

		if (cmd.start && sts.bad_free) begin
			res_granted_q <= '0;
			res_status_q  <= bsa_pkg::STATUS_BAD_ID;
		end else if (sts.done) begin
			if (alloc_s1 && found) begin
				res_granted_q <= bsa_pkg::SLOT_FIELD_W'(grant);
				res_status_q  <= bsa_pkg::STATUS_OK;
			end else begin
				res_granted_q <= '0;
				res_status_q  <= alloc_s1 ? bsa_pkg::STATUS_FULL : bsa_pkg::STATUS_OK;
			end
		end

		if (cmd.out_load) begin
			out_granted_q <= res_granted_q;
			out_status_q  <= res_status_q;
		end
	end

	assign granted_slot = out_granted_q;
	assign status       = out_status_q;

endmodule

`default_nettype wire

[tb/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_WORDS   = (bsa_pkg::CAPACITY + bsa_pkg::WORD_BITS - 1) /
		bsa_pkg::WORD_BITS;
	localparam int CYCLE_LIMIT = 600000;
	localparam int LONG_HOLD   = 120;
	localparam int TAIL_CYCLES = 30;

	typedef struct packed {
		logic [bsa_pkg::SLOT_FIELD_W-1:0] slot;
		logic [bsa_pkg::STATUS_W-1:0]     code;
	} slot_outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	bsa_req_if req_ch ();
	bsa_rsp_if rsp_ch ();
	bsa_cfg_if cfg_ch ();

	bitmap_slot_allocator_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the allocator state
	logic [bsa_pkg::WORD_BITS-1:0] slot_map [NUM_WORDS];
	logic [bsa_pkg::ACT_W-1:0]     active_count;
	slot_outcome_t                 awaited [$];

	int  errors        = 0;
	int  items_sent    = 0;
	int  results_seen  = 0;
	int  ok_replies    = 0;
	int  full_replies  = 0;
	int  bad_frees     = 0;
	int  cycle_count   = 0;
	int  hold_requests = 0;
	bit  offering      = 1'b0;

	// Receiver stall state
	int hold_seen    = 0;
	int hold_left    = 0;
	int pattern_kind = 0;
	int pattern_left = 0;
	int rx_cycle     = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Slot count actually in force: the register saturates at the capacity
	function automatic int slots_in_play();
		return (active_count > bsa_pkg::CAPACITY) ? bsa_pkg::CAPACITY : int'(active_count);
	endfunction

	// Random slot number within the field range
	function automatic logic [bsa_pkg::SLOT_FIELD_W-1:0] any_slot();
		return bsa_pkg::SLOT_FIELD_W'($urandom_range(0, bsa_pkg::CAPACITY - 1));
	endfunction

	// Apply one request to the shadow bitmap and return the reply it should get
	function automatic slot_outcome_t resolve_request(input logic m,
			input logic [bsa_pkg::SLOT_FIELD_W-1:0] s);
		slot_outcome_t res;
		int            lim;
		int            id;
		bit            found;
		lim      = slots_in_play();
		res.slot = '0;
		res.code = bsa_pkg::STATUS_OK;
		if (m == bsa_pkg::MODE_ALLOC) begin
			res.code = bsa_pkg::STATUS_FULL;
			found    = 1'b0;
			id       = 0;
			while (!found && id < lim) begin
				if (!slot_map[id / bsa_pkg::WORD_BITS][id % bsa_pkg::WORD_BITS]) begin
					slot_map[id / bsa_pkg::WORD_BITS][id % bsa_pkg::WORD_BITS] = 1'b1;
					res.slot = bsa_pkg::SLOT_FIELD_W'(id);
					res.code = bsa_pkg::STATUS_OK;
					found    = 1'b1;
				end
				id++;
			end
		end else if (int'(s) >= lim) begin
			res.code = bsa_pkg::STATUS_BAD_ID;
		end else begin
			slot_map[s / bsa_pkg::WORD_BITS][s % bsa_pkg::WORD_BITS] = 1'b0;
		end
		return res;
	endfunction

	// Mostly a slot that is really in use, otherwise anything in the field range
	function automatic logic [bsa_pkg::SLOT_FIELD_W-1:0] choose_release_slot();
		int lim;
		int start;
		int k;
		int s;
		lim = slots_in_play();
		if ($urandom_range(0, 99) < 80) begin
			start = $urandom_range(0, bsa_pkg::CAPACITY - 1);
			for (k = 0; k < bsa_pkg::CAPACITY; k++) begin
				s = (start + k) % bsa_pkg::CAPACITY;
				if (s < lim && slot_map[s / bsa_pkg::WORD_BITS][s % bsa_pkg::WORD_BITS])
					return bsa_pkg::SLOT_FIELD_W'(s);
			end
		end
		return any_slot();
	endfunction

	// Offer one item and record its reply once taken; valid stays high afterwards
	task automatic send_request(input logic m, input logic [bsa_pkg::SLOT_FIELD_W-1:0] s);
		slot_outcome_t expected;
		req_ch.valid        <= 1'b1;
		req_ch.mode         <= m;
		req_ch.release_slot <= s;
		offering = 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		expected = resolve_request(m, s);
		awaited  = {awaited, expected};
		items_sent++;
	endtask

	task automatic pause_sender(input int cycles);
		if (cycles > 0) begin
			req_ch.valid        <= 1'b0;
			req_ch.mode         <= 1'($urandom_range(0, 1));
			req_ch.release_slot <= any_slot();
			offering = 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Stop offering and wait for every outstanding reply
	task automatic settle();
		if (offering) begin
			req_ch.valid <= 1'b0;
			offering = 1'b0;
		end
		while (awaited.size() != 0) @(posedge clk);
	endtask

	task automatic write_active(input logic [bsa_pkg::ACT_W-1:0] value);
		cfg_ch.valid        <= 1'b1;
		cfg_ch.active_slots <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		active_count = value;
	endtask

	// One block of random traffic under a given slot count, sent in bursts
	task automatic run_phase(input logic [bsa_pkg::ACT_W-1:0] act, input int count,
			input int alloc_pct);
		int   burst_left;
		int   k;
		logic m;
		settle();
		write_active(act);
		burst_left = $urandom_range(1, 8);
		for (k = 0; k < count; k++) begin
			m = ($urandom_range(0, 99) < alloc_pct) ? bsa_pkg::MODE_ALLOC : bsa_pkg::MODE_FREE;
			if (m == bsa_pkg::MODE_FREE)
				send_request(m, choose_release_slot());
			else
				send_request(m, any_slot());
			burst_left--;
			if (burst_left == 0) begin
				pause_sender(($urandom_range(0, 3) == 0) ? $urandom_range(5, 25)
					: $urandom_range(0, 4));
				burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
					: $urandom_range(1, 8);
			end
		end
	endtask

	// Field extremes, freeing a free slot, reuse of the lowest hole
	task automatic test_basics();
		send_request(bsa_pkg::MODE_FREE, '0);
		send_request(bsa_pkg::MODE_FREE, bsa_pkg::SLOT_FIELD_W'(bsa_pkg::CAPACITY - 1));
		send_request(bsa_pkg::MODE_ALLOC, '0);
		send_request(bsa_pkg::MODE_ALLOC, bsa_pkg::SLOT_FIELD_W'(bsa_pkg::CAPACITY - 1));
		send_request(bsa_pkg::MODE_ALLOC, '0);
		send_request(bsa_pkg::MODE_FREE, bsa_pkg::SLOT_FIELD_W'(1));
		send_request(bsa_pkg::MODE_ALLOC, '0);
	endtask

	// Zero count, saturation, count lowered beneath slots in use
	task automatic test_active_limits();
		settle();
		write_active('0);
		send_request(bsa_pkg::MODE_ALLOC, '0);
		send_request(bsa_pkg::MODE_FREE, bsa_pkg::SLOT_FIELD_W'(5));
		send_request(bsa_pkg::MODE_FREE, '0);
		settle();
		write_active(11'h7FF);
		send_request(bsa_pkg::MODE_FREE, bsa_pkg::SLOT_FIELD_W'(bsa_pkg::CAPACITY - 1));
		send_request(bsa_pkg::MODE_ALLOC, '0);
		settle();
		write_active(bsa_pkg::ACT_W'(3));
		send_request(bsa_pkg::MODE_ALLOC, '0);
		send_request(bsa_pkg::MODE_FREE, bsa_pkg::SLOT_FIELD_W'(3));
		send_request(bsa_pkg::MODE_FREE, bsa_pkg::SLOT_FIELD_W'(2));
		send_request(bsa_pkg::MODE_ALLOC, '0);
		settle();
		write_active(bsa_pkg::ACT_W'(1));
		send_request(bsa_pkg::MODE_ALLOC, '0);
		send_request(bsa_pkg::MODE_FREE, '0);
		send_request(bsa_pkg::MODE_ALLOC, '0);
		settle();
		write_active(bsa_pkg::ACT_RESET);
		send_request(bsa_pkg::MODE_FREE, bsa_pkg::SLOT_FIELD_W'(3));
	endtask

	// Mostly allocations until the whole bitmap is used and scans run deep
	task automatic test_deep_fill();
		run_phase(bsa_pkg::ACT_RESET, 1050, 98);
	endtask

	// Output held off for a long stretch while items keep coming
	task automatic test_backpressure();
		int k;
		settle();
		hold_requests <= hold_requests + 1;
		for (k = 0; k < 8; k++) begin
			if (k[0])
				send_request(bsa_pkg::MODE_FREE, choose_release_slot());
			else
				send_request(bsa_pkg::MODE_ALLOC, any_slot());
		end
		settle();
	endtask

	// Mixed traffic across a spread of slot counts
	task automatic test_random_counts();
		int k;
		run_phase(11'h7FF, 150, 30);
		run_phase(bsa_pkg::ACT_W'(bsa_pkg::WORD_BITS), 100, 70);
		run_phase(bsa_pkg::ACT_W'(bsa_pkg::WORD_BITS + 1), 100, 70);
		run_phase(bsa_pkg::ACT_W'(1), 60, 50);
		run_phase('0, 20, 50);
		for (k = 0; k < 6; k++)
			run_phase(bsa_pkg::ACT_W'($urandom_range(1, bsa_pkg::CAPACITY)), 70, 55);
		run_phase(bsa_pkg::ACT_RESET, 60, 40);
	endtask

	// Compare one reply against the oldest awaited one
	task automatic check_reply();
		slot_outcome_t want;
		results_seen++;
		if (awaited.size() == 0) begin
			errors++;
			$display("%0t: reply with nothing awaited: slot %0d status %0d", $time,
				rsp_ch.granted_slot, rsp_ch.status);
		end else begin
			want = awaited.pop_front();
			if (rsp_ch.granted_slot !== want.slot) begin
				errors++;
				$display("%0t: granted_slot expected %0d actual %0d", $time, want.slot,
					rsp_ch.granted_slot);
			end
			if (rsp_ch.status !== want.code) begin
				errors++;
				$display("%0t: status expected %0d actual %0d", $time, want.code,
					rsp_ch.status);
			end
			case (want.code)
				bsa_pkg::STATUS_FULL:   full_replies++;
				bsa_pkg::STATUS_BAD_ID: bad_frees++;
				default:                ok_replies++;
			endcase
		end
	endtask

	// Reply checking and receiver stall pattern
	always @(posedge clk) begin
		rx_cycle++;
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			check_reply();
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			if (pattern_left == 0) begin
				pattern_kind = $urandom_range(0, 2);
				pattern_left = $urandom_range(5, 40);
			end
			pattern_left--;
			case (pattern_kind)
				0:       rsp_ch.ready <= 1'b1;
				1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
				default: rsp_ch.ready <= (rx_cycle % 4 == 0);
			endcase
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		for (int w = 0; w < NUM_WORDS; w++)
			slot_map[w] = '0;
		active_count = bsa_pkg::ACT_RESET;
		arst_n              <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.mode         <= bsa_pkg::MODE_ALLOC;
		req_ch.release_slot <= '0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.active_slots <= bsa_pkg::ACT_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_basics();
		test_active_limits();
		test_deep_fill();
		test_backpressure();
		test_random_counts();

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d requests: %0d ok, %0d out-of-space, %0d rejected frees",
			items_sent, ok_replies, full_replies, bad_frees);
		$display("slot counts from 0 to saturation, full bitmap, long output hold-off");
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

[files.f]
rtl/bsa_pkg.sv
rtl/bsa_if.sv
rtl/bsa_ctrl.sv
rtl/bsa_dp.sv
rtl/bitmap_slot_allocator_top.sv
tb/tb.sv
